// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/bawd_pkg.sv
`default_nettype none
package bawd_pkg;

   localparam int unsigned WORD_W = 16;

   localparam logic [2:0] CSR_A_SHIFT     = 3'd0;
   localparam logic [2:0] CSR_B_SHIFT     = 3'd1;
   localparam logic [2:0] CSR_DESCENDING  = 3'd2;
   localparam logic [2:0] CSR_MINTERM     = 3'd3;
   localparam logic [2:0] CSR_FIRST_MASK  = 3'd4;
   localparam logic [2:0] CSR_LAST_MASK   = 3'd5;
   localparam logic [2:0] CSR_BLIT_SIZE   = 3'd6;
   localparam logic [2:0] CSR_CHANNEL_USE = 3'd7;

   localparam logic [15:0] MASK_RESET = 16'hFFFF;

   typedef struct packed {
      logic [3:0]        a_shift;
      logic [3:0]        b_shift;
      logic              descending;
      logic              b_enable;
      logic [7:0]        minterm;
      logic              first_col;
      logic              row_end;
      logic [WORD_W-1:0] first_mask;
      logic [WORD_W-1:0] last_mask;
   } bawd_ctl_type;

endpackage
`default_nettype wire

// File: rtl/core/bawd_word_unit.sv
`default_nettype none
module bawd_word_unit
   import bawd_pkg::*;
(
   input  wire bawd_ctl_type      ctl,
   input  wire logic [WORD_W-1:0] a_word,
   input  wire logic [WORD_W-1:0] b_word,
   input  wire logic [WORD_W-1:0] c_word,
   input  wire logic [WORD_W-1:0] a_carry,
   input  wire logic [WORD_W-1:0] b_carry,
   output logic      [WORD_W-1:0] a_masked,
   output logic      [WORD_W-1:0] d_word
);

   logic [2*WORD_W-1:0] a_comb;
   logic [2*WORD_W-1:0] b_comb;
   logic [WORD_W-1:0]   a_aligned;
   logic [WORD_W-1:0]   b_aligned;
   logic [WORD_W-1:0]   b_sel;

   always_comb begin
      a_masked = a_word;
      if (ctl.first_col) begin
         a_masked = a_masked & ctl.first_mask;
      end
      if (ctl.row_end) begin
         a_masked = a_masked & ctl.last_mask;
      end
   end

   // Descending mode shifts left and ascending mode shifts right, each pulling bits in from the previous word.
   always_comb begin
      if (ctl.descending) begin
         a_comb    = {a_masked, a_carry} << ctl.a_shift;
         b_comb    = {b_word, b_carry} << ctl.b_shift;
         a_aligned = a_comb[2*WORD_W-1:WORD_W];
         b_aligned = b_comb[2*WORD_W-1:WORD_W];
      end else begin
         a_comb    = {a_carry, a_masked} >> ctl.a_shift;
         b_comb    = {b_carry, b_word} >> ctl.b_shift;
         a_aligned = a_comb[WORD_W-1:0];
         b_aligned = b_comb[WORD_W-1:0];
      end
      b_sel = ctl.b_enable ? b_aligned : b_word;
   end

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         d_word[i] = ctl.minterm[{a_aligned[i], b_sel[i], c_word[i]}];
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/blitter_area_word_datapath_top.sv
// Each accepted item is held in the input register, then moves into the result
// register and raises rsp_valid once that register is empty or being taken.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset is synchronous and active high: it clears both valid flags, the counts and
// the shifter carries, sets the blit-zero flag, and loads the register reset values.
`default_nettype none
`include "assert_macros.svh"
module blitter_area_word_datapath_top
   import bawd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_a_word,
   input  wire logic [15:0] req_b_word,
   input  wire logic [15:0] req_c_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_d_word,
   output logic             rsp_d_write,
   output logic             rsp_last_word,
   output logic             rsp_blit_zero
);

   logic [3:0]  a_shift_ff;
   logic [3:0]  b_shift_ff;
   logic        descending_ff;
   logic [7:0]  minterm_ff;
   logic [15:0] first_mask_ff;
   logic [15:0] last_mask_ff;
   logic [15:0] blit_size_ff;
   logic [3:0]  channel_use_ff;

   logic        s1_valid_ff;
   logic [15:0] s1_a_ff;
   logic [15:0] s1_b_ff;
   logic [15:0] s1_c_ff;

   logic [15:0] a_carry_ff;
   logic [15:0] b_carry_ff;
   logic [5:0]  col_cnt_ff;
   logic [9:0]  row_cnt_ff;
   logic        zero_seen_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_d_ff;
   logic        rsp_write_ff;
   logic        rsp_last_ff;
   logic        rsp_zero_ff;

   logic [6:0]   width_words;
   logic [10:0]  height_rows;
   logic         out_free;
   logic         s1_move;
   logic         row_end;
   logic         blit_end;
   logic         first_col;
   logic [15:0]  a_carry_use;
   logic [15:0]  b_carry_use;
   logic [15:0]  a_masked;
   logic [15:0]  d_word;
   logic         zero_in;
   bawd_ctl_type ctl;

   assign width_words = (blit_size_ff[5:0] == 6'd0) ? 7'd64 : {1'b0, blit_size_ff[5:0]};
   assign height_rows = (blit_size_ff[15:6] == 10'd0) ? 11'd1024
                                                      : {1'b0, blit_size_ff[15:6]};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   assign first_col   = (col_cnt_ff == 6'd0);
   assign row_end     = ({1'b0, col_cnt_ff} >= (width_words - 7'd1));
   assign blit_end    = row_end && ({1'b0, row_cnt_ff} >= (height_rows - 11'd1));
   assign a_carry_use = first_col ? 16'd0 : a_carry_ff;
   assign b_carry_use = first_col ? 16'd0 : b_carry_ff;

   always_comb begin
      ctl.a_shift    = a_shift_ff;
      ctl.b_shift    = b_shift_ff;
      ctl.descending = descending_ff;
      ctl.b_enable   = channel_use_ff[2];
      ctl.minterm    = minterm_ff;
      ctl.first_col  = first_col;
      ctl.row_end    = row_end;
      ctl.first_mask = first_mask_ff;
      ctl.last_mask  = last_mask_ff;
   end

   bawd_word_unit u_word (
      .ctl      (ctl),
      .a_word   (s1_a_ff),
      .b_word   (s1_b_ff),
      .c_word   (s1_c_ff),
      .a_carry  (a_carry_use),
      .b_carry  (b_carry_use),
      .a_masked (a_masked),
      .d_word   (d_word)
   );

   // A new blit starts when both counts are zero.
   assign zero_in = ((first_col && (row_cnt_ff == 10'd0)) || zero_seen_ff) && (d_word == 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_shift_ff     <= 4'd0;
         b_shift_ff     <= 4'd0;
         descending_ff  <= 1'b0;
         minterm_ff     <= 8'd0;
         first_mask_ff  <= MASK_RESET;
         last_mask_ff   <= MASK_RESET;
         blit_size_ff   <= 16'd0;
         channel_use_ff <= 4'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_A_SHIFT:     a_shift_ff     <= csr_wdata[3:0];
            CSR_B_SHIFT:     b_shift_ff     <= csr_wdata[3:0];
            CSR_DESCENDING:  descending_ff  <= csr_wdata[0];
            CSR_MINTERM:     minterm_ff     <= csr_wdata[7:0];
            CSR_FIRST_MASK:  first_mask_ff  <= csr_wdata;
            CSR_LAST_MASK:   last_mask_ff   <= csr_wdata;
            CSR_BLIT_SIZE:   blit_size_ff   <= csr_wdata;
            CSR_CHANNEL_USE: channel_use_ff <= csr_wdata[3:0];
            default:         minterm_ff     <= minterm_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_a_ff <= req_a_word;
         s1_b_ff <= req_b_word;
         s1_c_ff <= req_c_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_carry_ff   <= 16'd0;
         b_carry_ff   <= 16'd0;
         col_cnt_ff   <= 6'd0;
         row_cnt_ff   <= 10'd0;
         zero_seen_ff <= 1'b1;
      end else if (csr_write && (csr_index == CSR_BLIT_SIZE)) begin
         col_cnt_ff <= 6'd0;
         row_cnt_ff <= 10'd0;
      end else if (s1_move) begin
         a_carry_ff   <= a_masked;
         b_carry_ff   <= s1_b_ff;
         zero_seen_ff <= zero_in;
         if (blit_end) begin
            col_cnt_ff <= 6'd0;
            row_cnt_ff <= 10'd0;
         end else if (row_end) begin
            col_cnt_ff <= 6'd0;
            row_cnt_ff <= row_cnt_ff + 10'd1;
         end else begin
            col_cnt_ff <= col_cnt_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_move) begin
         rsp_d_ff     <= d_word;
         rsp_write_ff <= channel_use_ff[0];
         rsp_last_ff  <= blit_end;
         rsp_zero_ff  <= zero_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_d_word    = rsp_d_ff;
   assign rsp_d_write   = rsp_write_ff;
   assign rsp_last_word = rsp_last_ff;
   assign rsp_blit_zero = rsp_zero_ff;

   `ASSERT_NEXT(a_move_fills_out, clock, reset, s1_move, rsp_valid_ff)
   `ASSERT_SAME(a_stall_means_full, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff)
   `ASSERT_SAME(a_nonzero_clears_flag, clock, reset, rsp_valid_ff && (rsp_d_ff != 16'd0),
      !rsp_zero_ff)
   `ASSERT_NEXT(a_blit_end_restarts, clock, reset, s1_move && blit_end,
      (col_cnt_ff == 6'd0) && (row_cnt_ff == 10'd0))

endmodule
`default_nettype wire

// File: tb/sv/blitter_area_word_datapath_checker.sv
module blitter_area_word_datapath_checker
   import bawd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_a_word,
   input  logic [15:0] req_b_word,
   input  logic [15:0] req_c_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_d_word,
   input  logic        rsp_d_write,
   input  logic        rsp_last_word,
   input  logic        rsp_blit_zero,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WORD_W-1:0] d_word;
      logic              d_write;
      logic              last_word;
      logic              blit_zero;
   } blit_result_type;

   blit_result_type dest_word_q[$];

   logic [3:0]  a_shift_r;
   logic [3:0]  b_shift_r;
   logic        descending_r;
   logic [7:0]  minterm_r;
   logic [15:0] first_mask_r;
   logic [15:0] last_mask_r;
   logic [15:0] blit_size_r;
   logic [3:0]  channel_use_r;

   logic [15:0] a_prev;
   logic [15:0] b_prev;
   logic [5:0]  col_index;
   logic [9:0]  row_index;
   logic        zero_so_far;

   function automatic logic [15:0] barrel_shift(input logic [15:0] word,
                                                input logic [15:0] carry,
                                                input logic [3:0]  count,
                                                input logic        desc);
      logic [31:0] joined;
      if (desc) begin
         joined = {word, carry};
         joined = joined >> (5'd16 - {1'b0, count});
      end else begin
         joined = {carry, word};
         joined = joined >> count;
      end
      return joined[15:0];
   endfunction

   function automatic logic [15:0] apply_minterm(input logic [15:0] a,
                                                 input logic [15:0] b,
                                                 input logic [15:0] c,
                                                 input logic [7:0]  code);
      logic [15:0] d;
      for (int i = 0; i < 16; i++) begin
         d[i] = code[{a[i], b[i], c[i]}];
      end
      return d;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 100) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      case (index)
         CSR_A_SHIFT: begin
            a_shift_r = value[3:0];
         end
         CSR_B_SHIFT: begin
            b_shift_r = value[3:0];
         end
         CSR_DESCENDING: begin
            descending_r = value[0];
         end
         CSR_MINTERM: begin
            minterm_r = value[7:0];
         end
         CSR_FIRST_MASK: begin
            first_mask_r = value;
         end
         CSR_LAST_MASK: begin
            last_mask_r = value;
         end
         CSR_BLIT_SIZE: begin
            blit_size_r = value;
            col_index = '0;
            row_index = '0;
         end
         CSR_CHANNEL_USE: begin
            channel_use_r = value[3:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic predict_dest_word(input logic [15:0] a_word,
                                    input logic [15:0] b_word,
                                    input logic [15:0] c_word);
      int              width;
      int              height;
      logic            row_end;
      logic            blit_end;
      logic [15:0]     a_in;
      logic [15:0]     a_s;
      logic [15:0]     b_s;
      logic [15:0]     d;
      blit_result_type item;
      width = (blit_size_r[5:0] == 0) ? 64 : int'(blit_size_r[5:0]);
      height = (blit_size_r[15:6] == 0) ? 1024 : int'(blit_size_r[15:6]);
      a_in = a_word;
      if (col_index == 0 && row_index == 0) begin
         zero_so_far = 1'b1;
      end
      if (col_index == 0) begin
         a_prev = '0;
         b_prev = '0;
      end
      row_end = (int'(col_index) >= width - 1);
      blit_end = row_end && (int'(row_index) >= height - 1);
      if (col_index == 0) begin
         a_in = a_in & first_mask_r;
      end
      if (row_end) begin
         a_in = a_in & last_mask_r;
      end
      a_s = barrel_shift(a_in, a_prev, a_shift_r, descending_r);
      a_prev = a_in;
      b_s = barrel_shift(b_word, b_prev, b_shift_r, descending_r);
      b_prev = b_word;
      if (!channel_use_r[2]) begin
         b_s = b_word;
      end
      d = apply_minterm(a_s, b_s, c_word, minterm_r);
      if (d != 0) begin
         zero_so_far = 1'b0;
      end
      item.d_word = d;
      item.d_write = channel_use_r[0];
      item.last_word = blit_end;
      item.blit_zero = zero_so_far;
      dest_word_q.push_back(item);
      if (blit_end) begin
         col_index = '0;
         row_index = '0;
      end else if (row_end) begin
         col_index = '0;
         row_index = row_index + 10'd1;
      end else begin
         col_index = col_index + 6'd1;
      end
   endtask

   task automatic check_dest_word();
      blit_result_type want;
      if (dest_word_q.size() == 0) begin
         report_mismatch($sformatf("result with d_word %h but no item pending", rsp_d_word));
         return;
      end
      want = dest_word_q.pop_front();
      if (rsp_d_word !== want.d_word) begin
         report_mismatch($sformatf("d_word %h, expected %h", rsp_d_word, want.d_word));
      end
      if (rsp_d_write !== want.d_write) begin
         report_mismatch($sformatf("d_write %b, expected %b", rsp_d_write, want.d_write));
      end
      if (rsp_last_word !== want.last_word) begin
         report_mismatch($sformatf("last_word %b, expected %b",
                                   rsp_last_word, want.last_word));
      end
      if (rsp_blit_zero !== want.blit_zero) begin
         report_mismatch($sformatf("blit_zero %b, expected %b",
                                   rsp_blit_zero, want.blit_zero));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         a_shift_r = '0;
         b_shift_r = '0;
         descending_r = 1'b0;
         minterm_r = '0;
         first_mask_r = MASK_RESET;
         last_mask_r = MASK_RESET;
         blit_size_r = '0;
         channel_use_r = '0;
         a_prev = '0;
         b_prev = '0;
         col_index = '0;
         row_index = '0;
         zero_so_far = 1'b1;
         dest_word_q.delete();
      end else begin
         if (csr_write) begin
            write_register(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            predict_dest_word(req_a_word, req_b_word, req_c_word);
         end
         if (rsp_valid && rsp_ready) begin
            check_dest_word();
         end
      end
      pending_count <= dest_word_q.size();
   end

endmodule

// File: tb/sv/blitter_area_word_datapath_top_test.sv
module blitter_area_word_datapath_top_test;
   import bawd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_a_word = '0;
   logic [15:0] req_b_word = '0;
   logic [15:0] req_c_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_d_word;
   logic        rsp_d_write;
   logic        rsp_last_word;
   logic        rsp_blit_zero;
   int          fail_count;
   int          pending_count;
   bit          calm = 1'b0;

   blitter_area_word_datapath_top dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_word    (req_a_word),
      .req_b_word    (req_b_word),
      .req_c_word    (req_c_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_d_word    (rsp_d_word),
      .rsp_d_write   (rsp_d_write),
      .rsp_last_word (rsp_last_word),
      .rsp_blit_zero (rsp_blit_zero)
   );

   blitter_area_word_datapath_checker word_check (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_word    (req_a_word),
      .req_b_word    (req_b_word),
      .req_c_word    (req_c_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_d_word    (rsp_d_word),
      .rsp_d_write   (rsp_d_write),
      .rsp_last_word (rsp_last_word),
      .rsp_blit_zero (rsp_blit_zero),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 15);
   end

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic put_csr(input logic [2:0] index, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [3:0]  a_shift,
                               input logic [3:0]  b_shift,
                               input logic        descending,
                               input logic [7:0]  minterm,
                               input logic [15:0] first_mask,
                               input logic [15:0] last_mask,
                               input logic [15:0] blit_size,
                               input logic [3:0]  channel_use);
      put_csr(CSR_A_SHIFT, {12'h000, a_shift});
      put_csr(CSR_B_SHIFT, {12'h000, b_shift});
      put_csr(CSR_DESCENDING, {15'h0000, descending});
      put_csr(CSR_MINTERM, {8'h00, minterm});
      put_csr(CSR_FIRST_MASK, first_mask);
      put_csr(CSR_LAST_MASK, last_mask);
      put_csr(CSR_BLIT_SIZE, blit_size);
      put_csr(CSR_CHANNEL_USE, {12'h000, channel_use});
      csr_write <= 1'b0;
   endtask

   task automatic send_item(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_a_word <= a;
      req_b_word <= b;
      req_c_word <= c;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int          n_items;
      int          width;
      int          height;
      logic [15:0] size;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'h0000, 16'h0000, 16'h0000);
      settle();

      // Three-word rows, one row per blit, ascending with both masks active.
      program_regs(4'd4, 4'd15, 1'b0, 8'hCA, 16'h0FFF, 16'hFFF0, 16'h0043, 4'hF);
      send_item(16'hFFFF, 16'h8001, 16'h0000);
      send_item(16'h0000, 16'hFFFF, 16'hFFFF);
      send_item(16'h8001, 16'h0000, 16'h5A5A);
      send_item(16'hFFFF, 16'hFFFF, 16'h0000);
      send_item(16'h1234, 16'h8000, 16'hFFFF);
      send_item(16'h0001, 16'h0001, 16'h0001);
      settle();

      // Descending, B channel off so B bypasses its shifter, D writes off.
      program_regs(4'd15, 4'd0, 1'b1, 8'hF0, 16'hFF00, 16'h00FF, 16'h0082, 4'h0);
      send_item(16'h8001, 16'hFFFF, 16'h0000);
      send_item(16'hFFFF, 16'h0001, 16'hFFFF);
      send_item(16'h0F0F, 16'h8000, 16'h0000);
      send_item(16'hF0F0, 16'h7FFF, 16'hAAAA);
      settle();

      // Descending with zero shift, one-word blits, all-zero then all-one minterm.
      program_regs(4'd0, 4'd0, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF, 16'h0041, 4'h5);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'h1357, 16'h2468, 16'h0000);
      settle();
      program_regs(4'd0, 4'd0, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0041, 4'h5);
      send_item(16'h0000, 16'h0000, 16'h0000);
      send_item(16'h8000, 16'h0001, 16'h4000);
      settle();

      for (int phase = 0; phase < 14; phase++) begin
         calm = (phase == 4);
         if (phase == 0) begin
            program_regs(4'd15, 4'd15, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0040, 4'hF);
            n_items = 128;
         end else if (phase == 1) begin
            program_regs(4'd0, 4'd0, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0001, 4'h0);
            n_items = 60;
         end else begin
            if (phase == 2) begin
               size = 16'hFFFF;
               n_items = 40;
            end else begin
               width = ($urandom_range(0, 5) == 0) ? 63 : $urandom_range(1, 8);
               height = $urandom_range(1, 6);
               if (width == 63) begin
                  height = 1;
               end
               size = {10'(height), 6'(width)};
               n_items = width * height * ((40 + width * height - 1) / (width * height));
            end
            program_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         pick_word(), pick_word(), size, 4'($urandom_range(0, 15)));
         end
         for (int i = 0; i < n_items; i++) begin
            if (phase == 3 && i == 20) begin
               settle();
            end
            send_item(pick_word(), pick_word(), pick_word());
         end
         settle();
      end
      calm = 1'b0;

      settle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bawd_pkg.sv
rtl/core/bawd_word_unit.sv
rtl/core/blitter_area_word_datapath_top.sv
tb/sv/blitter_area_word_datapath_checker.sv
tb/sv/blitter_area_word_datapath_top_test.sv
